FILE: sv/ygbd_pkg.sv
package ygbd_pkg;

  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth = 30;
  localparam logic [CfgIndexWidth-1:0] RegClassCount = 3'd0;
  localparam logic [CfgIndexWidth-1:0] RegGridWidth = 3'd1;
  localparam logic [CfgIndexWidth-1:0] RegGridHeight = 3'd2;
  localparam logic [CfgIndexWidth-1:0] RegGridStride = 3'd3;
  localparam logic [CfgIndexWidth-1:0] RegScoreThreshold = 3'd4;
  localparam logic [CfgIndexWidth-1:0] RegAnchorWidths = 3'd5;
  localparam logic [CfgIndexWidth-1:0] RegAnchorHeights = 3'd6;

  localparam logic [63:0] ExpStepQ32 = 64'd4228380000;
  localparam int unsigned BoxValues = 4;
  localparam int unsigned RecordDepth = 2;

  typedef struct packed {
    logic [7:0]  class_count;
    logic [7:0]  grid_width;
    logic [7:0]  grid_height;
    logic [6:0]  grid_stride;
    logic [15:0] score_threshold;
    logic [29:0] anchor_widths;
    logic [29:0] anchor_heights;
  } cfg_t;

  typedef struct packed {
    logic [BoxValues-1:0][15:0] box;
    logic [15:0] obj;
    logic [15:0] best;
    logic [6:0]  cls;
    logic [1:0]  anchor;
    logic [6:0]  col;
    logic [6:0]  row;
  } rec_t;

endpackage

FILE: sv/yolo_grid_box_decode.sv
// The front end updates its state on each accepted logit; a record is queued on the beat of its last class.
// The back end decodes one record at a time, using six reads of the sigmoid ROM.
// A record of four box values, objectness and N classes spans 5 + N input beats.
// When records come faster than the back end decodes them, full is raised while the queue is full.
// Reset is asynchronous and active low; it loads the default register values and clears counters.
module yolo_grid_box_decode import ygbd_pkg::*; #(
  parameter int unsigned MAX_CLASSES = 128,
  parameter int unsigned ANCHORS_PER_CELL = 3,
  parameter int unsigned MAX_GRID = 128,
  parameter int unsigned SIGMOID_ENTRIES = 1024
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CfgIndexWidth-1:0] cfg_index_i,
  input  logic [CfgDataWidth-1:0]  cfg_data_i,
  input  logic                     push_i,
  output logic                     full_o,
  input  logic [15:0]              logit_value_i,
  input  logic                     start_of_map_i,
  output logic                     empty_o,
  input  logic                     pop_i,
  output logic [6:0]               class_index_o,
  output logic [15:0]              confidence_o,
  output logic [15:0]              box_left_o,
  output logic [15:0]              box_top_o,
  output logic [15:0]              box_right_o,
  output logic [15:0]              box_bottom_o
);

  cfg_t cfg_q;
  rec_t rec_in, rec_out;
  logic accept, rec_push, rec_full, rec_empty, rec_pop;

  assign cfg_ready_o = 1'b1;
  assign full_o = rec_full;
  assign accept = push_i && !rec_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.class_count <= 8'd80;
      cfg_q.grid_width <= 8'd80;
      cfg_q.grid_height <= 8'd80;
      cfg_q.grid_stride <= 7'd8;
      cfg_q.score_threshold <= 16'd26214;
      cfg_q.anchor_widths <= 30'd34619402;
      cfg_q.anchor_heights <= 30'd24147981;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegClassCount:     cfg_q.class_count <= cfg_data_i[7:0];
        RegGridWidth:      cfg_q.grid_width <= cfg_data_i[7:0];
        RegGridHeight:     cfg_q.grid_height <= cfg_data_i[7:0];
        RegGridStride:     cfg_q.grid_stride <= cfg_data_i[6:0];
        RegScoreThreshold: cfg_q.score_threshold <= cfg_data_i[15:0];
        RegAnchorWidths:   cfg_q.anchor_widths <= cfg_data_i;
        RegAnchorHeights:  cfg_q.anchor_heights <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ygbd_front #(
    .MAX_CLASSES(MAX_CLASSES),
    .ANCHORS_PER_CELL(ANCHORS_PER_CELL),
    .MAX_GRID(MAX_GRID)
  ) u_front (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_i(cfg_q),
    .accept_i(accept),
    .logit_value_i(logit_value_i),
    .start_of_map_i(start_of_map_i),
    .rec_push_o(rec_push),
    .rec_o(rec_in)
  );

  ygbd_queue u_queue (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .push_i(rec_push),
    .data_i(rec_in),
    .full_o(rec_full),
    .pop_i(rec_pop),
    .empty_o(rec_empty),
    .data_o(rec_out)
  );

  ygbd_back #(
    .SIGMOID_ENTRIES(SIGMOID_ENTRIES)
  ) u_back (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_i(cfg_q),
    .rec_empty_i(rec_empty),
    .rec_i(rec_out),
    .rec_pop_o(rec_pop),
    .pop_i(pop_i),
    .empty_o(empty_o),
    .class_index_o(class_index_o),
    .confidence_o(confidence_o),
    .box_left_o(box_left_o),
    .box_top_o(box_top_o),
    .box_right_o(box_right_o),
    .box_bottom_o(box_bottom_o)
  );

endmodule

FILE: sv/ygbd_front.sv
module ygbd_front import ygbd_pkg::*; #(
  parameter int unsigned MAX_CLASSES = 128,
  parameter int unsigned ANCHORS_PER_CELL = 3,
  parameter int unsigned MAX_GRID = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        accept_i,
  input  logic [15:0] logit_value_i,
  input  logic        start_of_map_i,
  output logic        rec_push_o,
  output rec_t        rec_o
);

  logic [7:0] pos_q, pos_d, pos;
  logic [1:0] anchor_q, anchor_d, anchor;
  logic [6:0] col_q, col_d, col;
  logic [6:0] row_q, row_d, row;
  logic signed [15:0] best_q, best_d;
  logic [6:0] cls_q, cls_d;
  logic [15:0] obj_q, obj_d;
  logic [BoxValues-1:0][15:0] box_q, box_d;
  logic [7:0] cc, gw, gh;
  logic [8:0] last;
  logic is_last;

  always_comb begin
    if (cfg_i.class_count == 8'd0) cc = 8'd1;
    else if (cfg_i.class_count > 8'(MAX_CLASSES)) cc = 8'(MAX_CLASSES);
    else cc = cfg_i.class_count;
    if (cfg_i.grid_width == 8'd0) gw = 8'd1;
    else if ({1'b0, cfg_i.grid_width} > 9'(MAX_GRID)) gw = 8'(MAX_GRID);
    else gw = cfg_i.grid_width;
    if (cfg_i.grid_height == 8'd0) gh = 8'd1;
    else if ({1'b0, cfg_i.grid_height} > 9'(MAX_GRID)) gh = 8'(MAX_GRID);
    else gh = cfg_i.grid_height;
    last = 9'd4 + {1'b0, cc};
  end

  always_comb begin
    pos = start_of_map_i ? 8'd0 : pos_q;
    anchor = start_of_map_i ? 2'd0 : anchor_q;
    col = start_of_map_i ? 7'd0 : col_q;
    row = start_of_map_i ? 7'd0 : row_q;
    box_d = box_q;
    obj_d = obj_q;
    best_d = best_q;
    cls_d = cls_q;
    if (pos < 8'd4) begin
      box_d[pos[1:0]] = logit_value_i;
    end else if (pos == 8'd4) begin
      obj_d = logit_value_i;
    end else if (pos == 8'd5 || $signed(logit_value_i) > best_q) begin
      best_d = $signed(logit_value_i);
      cls_d = 7'(pos - 8'd5);
    end
    is_last = ({1'b0, pos} >= last);
    pos_d = pos + 8'd1;
    anchor_d = anchor;
    col_d = col;
    row_d = row;
    if (is_last) begin
      pos_d = 8'd0;
      anchor_d = anchor + 2'd1;
      if ({1'b0, anchor_d} >= 3'(ANCHORS_PER_CELL)) begin
        anchor_d = 2'd0;
        col_d = col + 7'd1;
        if (({1'b0, col} + 8'd1) >= gw) begin
          col_d = 7'd0;
          row_d = row + 7'd1;
          if (({1'b0, row} + 8'd1) >= gh) row_d = 7'd0;
        end
      end
    end
  end

  assign rec_push_o = accept_i && is_last;

  always_comb begin
    rec_o.box = box_d;
    rec_o.obj = obj_d;
    rec_o.best = best_d;
    rec_o.cls = cls_d;
    rec_o.anchor = anchor;
    rec_o.col = col;
    rec_o.row = row;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= 8'd0;
      anchor_q <= 2'd0;
      col_q <= 7'd0;
      row_q <= 7'd0;
      best_q <= 16'sd0;
      cls_q <= 7'd0;
      obj_q <= 16'd0;
    end else if (accept_i) begin
      pos_q <= pos_d;
      anchor_q <= anchor_d;
      col_q <= col_d;
      row_q <= row_d;
      best_q <= best_d;
      cls_q <= cls_d;
      obj_q <= obj_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) box_q <= box_d;
  end

`ifndef NO_ASSERTIONS
  a_pos_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_push_o |=> pos_q == 8'd0)
    else $error("Element position not cleared after a record.");
`endif

endmodule

FILE: sv/ygbd_queue.sv
module ygbd_queue import ygbd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  rec_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output rec_t data_o
);

  rec_t mem_q [RecordDepth];
  logic wr_q, rd_q;
  logic [1:0] count_q;

  assign full_o = (count_q == 2'(RecordDepth));
  assign empty_o = (count_q == 2'd0);
  assign data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      if (push_i && !pop_i) count_q <= count_q + 2'd1;
      else if (pop_i && !push_i) count_q <= count_q - 2'd1;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("Record queue written while full.");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("Record queue read while empty.");
`endif

endmodule

FILE: sv/ygbd_back.sv
module ygbd_back import ygbd_pkg::*; #(
  parameter int unsigned SIGMOID_ENTRIES = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        rec_empty_i,
  input  rec_t        rec_i,
  output logic        rec_pop_o,
  input  logic        pop_i,
  output logic        empty_o,
  output logic [6:0]  class_index_o,
  output logic [15:0] confidence_o,
  output logic [15:0] box_left_o,
  output logic [15:0] box_top_o,
  output logic [15:0] box_right_o,
  output logic [15:0] box_bottom_o
);

  localparam int unsigned IW = $clog2(SIGMOID_ENTRIES);
  localparam int unsigned Half = SIGMOID_ENTRIES / 2;
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_RD_OBJ = 4'd1;
  localparam logic [3:0] ST_RD_BEST = 4'd2;
  localparam logic [3:0] ST_RD_X = 4'd3;
  localparam logic [3:0] ST_RD_Y = 4'd4;
  localparam logic [3:0] ST_RD_W = 4'd5;
  localparam logic [3:0] ST_RD_H = 4'd6;
  localparam logic [3:0] ST_CAP_H = 4'd7;
  localparam logic [3:0] ST_MUL1 = 4'd8;
  localparam logic [3:0] ST_MUL2 = 4'd9;
  localparam logic [3:0] ST_OUT = 4'd10;

  typedef logic [15:0] sig_table_t [SIGMOID_ENTRIES];

  function automatic logic [63:0] div_round(logic [63:0] num, logic [63:0] den);
    logic [63:0] n, q, r;
    int i;
    n = num + (den >> 1);
    q = '0;
    r = '0;
    for (i = 63; i >= 0; i--) begin
      r = {r[62:0], n[i]};
      if (r >= den) begin
        r = r - den;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic sig_table_t build_table();
    sig_table_t t;
    logic [63:0] e, den, hi, lo;
    logic [127:0] p;
    int k;
    t = '{default: 16'h0};
    e = 64'd1 << 32;
    for (k = 0; k <= int'(Half); k++) begin
      den = (64'd1 << 32) + e;
      hi = div_round(64'd1 << 48, den);
      lo = div_round(e << 16, den);
      if (hi > 64'd65535) hi = 64'd65535;
      if (lo > 64'd65535) lo = 64'd65535;
      if (int'(Half) + k < int'(SIGMOID_ENTRIES)) t[int'(Half) + k] = hi[15:0];
      if (int'(Half) - k >= 0) t[int'(Half) - k] = lo[15:0];
      p = {64'd0, e} * {64'd0, ExpStepQ32};
      p = (p + (128'd1 << 31)) >> 32;
      e = p[63:0];
    end
    return t;
  endfunction

  localparam sig_table_t SigTable = build_table();

  function automatic logic [IW-1:0] sig_index(logic [15:0] logit);
    logic signed [16:0] ix;
    logic [IW-1:0] r;
    ix = 17'($signed(logit) >>> 2) + 17'(Half);
    if (ix[16]) r = '0;
    else if (ix > $signed(17'(SIGMOID_ENTRIES - 1))) r = IW'(SIGMOID_ENTRIES - 1);
    else r = ix[IW-1:0];
    return r;
  endfunction

  function automatic logic [15:0] to_q12_4(logic signed [49:0] v);
    logic signed [49:0] s;
    logic signed [21:0] r;
    logic [15:0] o;
    s = (v + 50'sd134217728) >>> 28;
    r = s[21:0];
    if (r > 22'sd32767) o = 16'h7fff;
    else if (r < -22'sd32768) o = 16'h8000;
    else o = r[15:0];
    return o;
  endfunction

  logic [3:0] step_q, step_d;
  rec_t rec_q;
  logic [IW-1:0] rom_addr;
  logic [15:0] rom_q;
  logic [5:0][15:0] sig_q;
  logic [31:0] conf_prod_q, sqw_q, sqh_q;
  logic signed [33:0] mx_q, my_q;
  logic [15:0] conf_q;
  logic [42:0] hw_q, hh_q;
  logic [9:0] aw, ah;
  logic signed [25:0] ax, ay;
  logic signed [49:0] cx, cy, x0, y0, x1, y1;
  logic start, pass, res_valid_q;

  assign start = (step_q == ST_IDLE) && !rec_empty_i && (!res_valid_q || pop_i);
  assign rec_pop_o = start;
  assign empty_o = !res_valid_q;

  always_comb begin
    step_d = step_q;
    if (start) step_d = ST_RD_OBJ;
    else if (step_q == ST_OUT) step_d = ST_IDLE;
    else if (step_q != ST_IDLE) step_d = step_q + 4'd1;
  end

  always_comb begin
    unique case (step_q)
      ST_RD_OBJ:  rom_addr = sig_index(rec_q.obj);
      ST_RD_BEST: rom_addr = sig_index(rec_q.best);
      ST_RD_X:    rom_addr = sig_index(rec_q.box[0]);
      ST_RD_Y:    rom_addr = sig_index(rec_q.box[1]);
      ST_RD_W:    rom_addr = sig_index(rec_q.box[2]);
      default:    rom_addr = sig_index(rec_q.box[3]);
    endcase
  end

  always_ff @(posedge clk_i) begin
    rom_q <= SigTable[rom_addr];
  end

  always_comb begin
    case (rec_q.anchor)
      2'd0: begin
        aw = cfg_i.anchor_widths[9:0];
        ah = cfg_i.anchor_heights[9:0];
      end
      2'd1: begin
        aw = cfg_i.anchor_widths[19:10];
        ah = cfg_i.anchor_heights[19:10];
      end
      2'd2: begin
        aw = cfg_i.anchor_widths[29:20];
        ah = cfg_i.anchor_heights[29:20];
      end
      default: begin
        aw = 10'd0;
        ah = 10'd0;
      end
    endcase
    ax = $signed({3'd0, rec_q.col, 16'd0}) + $signed({9'd0, sig_q[2], 1'b0}) - 26'sd32768;
    ay = $signed({3'd0, rec_q.row, 16'd0}) + $signed({9'd0, sig_q[3], 1'b0}) - 26'sd32768;
    cx = 50'(mx_q) <<< 16;
    cy = 50'(my_q) <<< 16;
    x0 = cx - $signed({7'd0, hw_q});
    y0 = cy - $signed({7'd0, hh_q});
    x1 = cx + $signed({7'd0, hw_q});
    y1 = cy + $signed({7'd0, hh_q});
    pass = (conf_q >= cfg_i.score_threshold) && (x1 > 50'sd0) && (y1 > 50'sd0);
  end

  always_ff @(posedge clk_i) begin
    if (start) rec_q <= rec_i;
    case (step_q)
      ST_RD_BEST: sig_q[0] <= rom_q;
      ST_RD_X:    sig_q[1] <= rom_q;
      ST_RD_Y:    sig_q[2] <= rom_q;
      ST_RD_W:    sig_q[3] <= rom_q;
      ST_RD_H:    sig_q[4] <= rom_q;
      ST_CAP_H:   sig_q[5] <= rom_q;
      default: ;
    endcase
    if (step_q == ST_MUL1) begin
      conf_prod_q <= sig_q[0] * sig_q[1];
      mx_q <= 34'(ax * $signed({1'b0, cfg_i.grid_stride}));
      my_q <= 34'(ay * $signed({1'b0, cfg_i.grid_stride}));
      sqw_q <= sig_q[4] * sig_q[4];
      sqh_q <= sig_q[5] * sig_q[5];
    end
    if (step_q == ST_MUL2) begin
      conf_q <= 16'((33'(conf_prod_q) + 33'd32768) >> 16);
      hw_q <= {42'(sqw_q * aw), 1'b0};
      hh_q <= {42'(sqh_q * ah), 1'b0};
    end
    if (step_q == ST_OUT && pass) begin
      class_index_o <= rec_q.cls;
      confidence_o <= conf_q;
      box_left_o <= to_q12_4(x0);
      box_top_o <= to_q12_4(y0);
      box_right_o <= to_q12_4(x1);
      box_bottom_o <= to_q12_4(y1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ST_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      step_q <= step_d;
      if (step_q == ST_OUT && pass) res_valid_q <= 1'b1;
      else if (pop_i && res_valid_q) res_valid_q <= 1'b0;
    end
  end

`ifndef NO_ASSERTIONS
  a_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q != ST_IDLE) |-> !res_valid_q)
    else $error("Result slot occupied while a record is decoded.");
`endif

endmodule

FILE: tb/sv/box_decode_checker.sv
module box_decode_checker import ygbd_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  input  logic                     cfg_ready_i,
  input  logic [CfgIndexWidth-1:0] cfg_index_i,
  input  logic [CfgDataWidth-1:0]  cfg_data_i,
  input  logic                     push_i,
  input  logic                     full_i,
  input  logic [15:0]              logit_value_i,
  input  logic                     start_of_map_i,
  input  logic                     empty_i,
  input  logic                     pop_i,
  input  logic [6:0]               class_index_i,
  input  logic [15:0]              confidence_i,
  input  logic [15:0]              box_left_i,
  input  logic [15:0]              box_top_i,
  input  logic [15:0]              box_right_i,
  input  logic [15:0]              box_bottom_i,
  output int                       mismatches_o,
  output int                       boxes_waiting_o,
  output int                       boxes_seen_o
);

  localparam int SigEntries = 1024;
  localparam int AnchorsPerCell = 3;
  localparam int MaxClasses = 128;
  localparam int MaxGrid = 128;

  typedef struct packed {
    logic [6:0]  cls;
    logic [15:0] conf;
    logic [15:0] left;
    logic [15:0] top;
    logic [15:0] right;
    logic [15:0] bottom;
  } box_t;

  box_t pending_boxes[$];
  logic [15:0] sig_rom[SigEntries];
  cfg_t cfg;

  int elem_pos, anchor_pos, col, row, best_logit, best_cls, obj_logit;
  int raw_box[4];

  initial begin
    longint unsigned e, den, hi, lo;
    e = 64'd1 << 32;
    for (int k = 0; k <= SigEntries / 2; k++) begin
      den = (64'd1 << 32) + e;
      hi = ((64'd1 << 48) + den / 2) / den;
      lo = ((e << 16) + den / 2) / den;
      if (hi > 65535) hi = 65535;
      if (lo > 65535) lo = 65535;
      if (SigEntries / 2 + k < SigEntries) sig_rom[SigEntries / 2 + k] = hi[15:0];
      if (SigEntries / 2 - k >= 0) sig_rom[SigEntries / 2 - k] = lo[15:0];
      e = (e * ExpStepQ32 + (64'd1 << 31)) >> 32;
    end
  end

  function automatic longint unsigned sigmoid(input int logit);
    int idx;
    idx = ((logit + 32768) >>> 2) - 8192 + SigEntries / 2;
    if (idx < 0) idx = 0;
    if (idx > SigEntries - 1) idx = SigEntries - 1;
    return 64'(sig_rom[idx]);
  endfunction

  function automatic logic [15:0] to_pixels(input longint v);
    longint r;
    r = ((v + (64'sd1 <<< 27) + (64'sd1 <<< 50)) >>> 28) - (64'sd1 <<< 22);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function automatic int clip(input int v, input int lo, input int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  task automatic take_logit(input logic [15:0] raw, input logic som);
    int v, last, pos, sh_bits;
    longint unsigned conf, sx, sy, sw, sh, aw, ah;
    longint cx, cy, hw, hh, x0, y0, x1, y1;
    box_t b;
    v = $signed(raw);
    last = 4 + clip(cfg.class_count, 1, MaxClasses);
    if (som) begin
      elem_pos = 0; anchor_pos = 0; col = 0; row = 0;
    end
    pos = elem_pos;
    if (pos < 4) raw_box[pos] = v;
    else if (pos == 4) obj_logit = v;
    else if (pos == 5 || v > best_logit) begin
      best_logit = v;
      best_cls = (pos - 5) & 8'h7f;
    end
    if (pos < last) begin
      elem_pos = pos + 1;
      return;
    end
    conf = (sigmoid(obj_logit) * sigmoid(best_logit) + 32768) >> 16;
    if (conf > 65535) conf = 65535;
    sx = sigmoid(raw_box[0]); sy = sigmoid(raw_box[1]);
    sw = sigmoid(raw_box[2]); sh = sigmoid(raw_box[3]);
    sh_bits = 10 * anchor_pos;
    aw = (cfg.anchor_widths >> sh_bits) & 10'h3ff;
    ah = (cfg.anchor_heights >> sh_bits) & 10'h3ff;
    cx = (longint'(2 * sx) - 32768 + longint'(col) * 65536) * longint'(cfg.grid_stride) * 65536;
    cy = (longint'(2 * sy) - 32768 + longint'(row) * 65536) * longint'(cfg.grid_stride) * 65536;
    hw = longint'(2 * sw * sw * aw);
    hh = longint'(2 * sh * sh * ah);
    x0 = cx - hw; y0 = cy - hh; x1 = cx + hw; y1 = cy + hh;
    elem_pos = 0;
    anchor_pos++;
    if (anchor_pos >= AnchorsPerCell) begin
      anchor_pos = 0;
      col++;
      if (col >= clip(cfg.grid_width, 1, MaxGrid)) begin
        col = 0;
        row++;
        if (row >= clip(cfg.grid_height, 1, MaxGrid)) row = 0;
      end
    end
    if (conf < cfg.score_threshold || x1 <= 0 || y1 <= 0) return;
    b.cls = best_cls[6:0];
    b.conf = conf[15:0];
    b.left = to_pixels(x0);
    b.top = to_pixels(y0);
    b.right = to_pixels(x1);
    b.bottom = to_pixels(y1);
    pending_boxes.push_back(b);
  endtask

  task automatic check_box();
    box_t e;
    if (pending_boxes.size() == 0) begin
      mismatches_o++;
      if (mismatches_o <= 10) $display("unexpected box beat: class %0d conf %0d",
                                       class_index_i, confidence_i);
      return;
    end
    e = pending_boxes.pop_front();
    if (e.cls !== class_index_i || e.conf !== confidence_i || e.left !== box_left_i ||
        e.top !== box_top_i || e.right !== box_right_i || e.bottom !== box_bottom_i) begin
      mismatches_o++;
      if (mismatches_o <= 10) begin
        $display("box mismatch exp cls %0d conf %0d box %0d %0d %0d %0d", e.cls, e.conf,
                 $signed(e.left), $signed(e.top), $signed(e.right), $signed(e.bottom));
        $display("             got cls %0d conf %0d box %0d %0d %0d %0d", class_index_i,
                 confidence_i, $signed(box_left_i), $signed(box_top_i),
                 $signed(box_right_i), $signed(box_bottom_i));
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg = '{class_count: 8'd80, grid_width: 8'd80, grid_height: 8'd80, grid_stride: 7'd8,
              score_threshold: 16'd26214, anchor_widths: 30'd34619402,
              anchor_heights: 30'd24147981};
      elem_pos = 0; anchor_pos = 0; col = 0; row = 0;
      best_logit = 0; best_cls = 0; obj_logit = 0;
      raw_box = '{default: 0};
      pending_boxes.delete();
      mismatches_o = 0;
      boxes_seen_o = 0;
    end else begin
      if (push_i && !full_i) take_logit(logit_value_i, start_of_map_i);
      if (pop_i && !empty_i) begin
        boxes_seen_o++;
        check_box();
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          RegClassCount: cfg.class_count = cfg_data_i[7:0];
          RegGridWidth: cfg.grid_width = cfg_data_i[7:0];
          RegGridHeight: cfg.grid_height = cfg_data_i[7:0];
          RegGridStride: cfg.grid_stride = cfg_data_i[6:0];
          RegScoreThreshold: cfg.score_threshold = cfg_data_i[15:0];
          RegAnchorWidths: cfg.anchor_widths = cfg_data_i;
          RegAnchorHeights: cfg.anchor_heights = cfg_data_i;
          default: ;
        endcase
      end
    end
    boxes_waiting_o = pending_boxes.size();
  end

endmodule

FILE: tb/sv/tb_top.sv
module tb_top;
  import ygbd_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIndexWidth-1:0] cfg_index_i = RegClassCount;
  logic [CfgDataWidth-1:0] cfg_data_i = '0;
  logic push_i = 1'b0;
  logic full_o;
  logic [15:0] logit_value_i = '0;
  logic start_of_map_i = 1'b0;
  logic empty_o;
  logic pop_i = 1'b0;
  logic [6:0] class_index_o;
  logic [15:0] confidence_o, box_left_o, box_top_o, box_right_o, box_bottom_o;

  int mismatches, boxes_waiting, boxes_seen;
  int burst_left = 0;
  int logits_sent = 0;
  int phases_run = 0;
  int idle_cycles = 0;
  int hold_left = 0;
  logic hold_ask = 1'b0;
  logic hold_done = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  yolo_grid_box_decode u_top (.*);

  box_decode_checker u_checker (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .push_i, .full_i(full_o), .logit_value_i, .start_of_map_i, .empty_i(empty_o), .pop_i,
    .class_index_i(class_index_o), .confidence_i(confidence_o), .box_left_i(box_left_o),
    .box_top_i(box_top_o), .box_right_i(box_right_o), .box_bottom_i(box_bottom_o),
    .mismatches_o(mismatches), .boxes_waiting_o(boxes_waiting), .boxes_seen_o(boxes_seen)
  );

  // The receiver switches between stall patterns and takes one long hold-off when asked.
  always @(negedge clk_i) begin
    if (hold_ask && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= 400;
      pop_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      pop_i <= 1'b0;
    end else begin
      case (($urandom_range(0, 2) + ($urandom() % 2)) % 3)
        0: pop_i <= 1'b1;
        1: pop_i <= 1'($urandom_range(0, 1));
        default: pop_i <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if ((push_i && !full_o) || (pop_i && !empty_o) || (cfg_valid_i && cfg_ready_o) ||
        hold_left > 0)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("watchdog expired with %0d boxes outstanding", boxes_waiting);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_logit(input logic [15:0] v, input logic som);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        push_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    push_i <= 1'b1;
    logit_value_i <= v;
    start_of_map_i <= som;
    do @(posedge clk_i); while (full_o);
    @(negedge clk_i);
    logits_sent++;
  endtask

  task automatic settle();
    push_i <= 1'b0;
    wait (boxes_waiting == 0);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIndexWidth-1:0] idx, input logic [29:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic write_all(input logic [7:0] cc, input logic [7:0] gw, input logic [7:0] gh,
                           input logic [6:0] stride, input logic [15:0] thr,
                           input logic [29:0] aw, input logic [29:0] ah);
    write_reg(RegClassCount, 30'(cc));
    write_reg(RegGridWidth, 30'(gw));
    write_reg(RegGridHeight, 30'(gh));
    write_reg(RegGridStride, 30'(stride));
    write_reg(RegScoreThreshold, 30'(thr));
    write_reg(RegAnchorWidths, aw);
    write_reg(RegAnchorHeights, ah);
  endtask

  function automatic logic [15:0] pick_logit(input int slot);
    if ($urandom_range(0, 24) == 0) return 16'($urandom());
    if (slot < 4) return 16'($signed($urandom_range(0, 1600)) - 800);
    if (slot == 4) return 16'($signed($urandom_range(0, 1800)) - 300);
    return 16'($signed($urandom_range(0, 2000)) - 1000);
  endfunction

  task automatic send_record(input int cc, input int count, input logic first);
    for (int i = 0; i < count; i++)
      send_logit(pick_logit(i), (first && i == 0) || ($urandom_range(0, 99) == 0));
  endtask

  initial begin
    int cc, cc_eff, records;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_record(80, 85, 1'b1);
    settle();

    write_all(8'd1, 8'd1, 8'd1, 7'd64, 16'd0, 30'h3fffffff, 30'h3fffffff);
    send_logit(16'h7fff, 1'b1); send_logit(16'h8000, 1'b0);
    send_logit(16'h7fff, 1'b0); send_logit(16'h8000, 1'b0);
    send_logit(16'h7fff, 1'b0); send_logit(16'h8000, 1'b0);
    send_logit(16'h8000, 1'b0); send_logit(16'h7fff, 1'b0);
    send_logit(16'h8000, 1'b0); send_logit(16'h7fff, 1'b0);
    send_logit(16'h8000, 1'b0); send_logit(16'h7fff, 1'b0);
    for (int i = 0; i < 6; i++) send_logit(16'h0000, 1'b0);
    settle();

    write_all(8'd0, 8'd0, 8'd0, 7'd0, 16'hffff, 30'd0, 30'd0);
    for (int i = 0; i < 6; i++) send_logit(16'h7fff, 1'b0);
    settle();

    // Leave a record open past the end of a shorter one, then shrink the class count.
    write_all(8'd6, 8'd2, 8'd2, 7'd8, 16'd0, 30'd34619402, 30'd24147981);
    for (int i = 0; i < 10; i++) send_logit(pick_logit(i), i == 0);
    settle();
    write_reg(RegClassCount, 30'd2);
    send_logit(16'h0100, 1'b0);
    settle();

    while (logits_sent < 420) begin
      phases_run++;
      case ($urandom_range(0, 9))
        0: cc = 255;
        1: cc = 0;
        default: cc = $urandom_range(1, 8);
      endcase
      cc_eff = (cc == 0) ? 1 : (cc > 128 ? 128 : cc);
      write_all(8'(cc), 8'(($urandom_range(0, 7) == 0) ? 255 : $urandom_range(0, 4)),
                8'(($urandom_range(0, 7) == 0) ? 128 : $urandom_range(0, 4)),
                7'(($urandom_range(0, 5) == 0) ? 127 : $urandom_range(0, 40)),
                16'(($urandom_range(0, 5) == 0) ? 65535 : $urandom_range(0, 30000)),
                30'($urandom()), 30'($urandom()));
      records = (cc_eff > 8) ? 1 : $urandom_range(3, 12);
      if (phases_run == 3) begin
        hold_ask <= 1'b1;
        records = 30;
      end
      for (int r = 0; r < records; r++) begin
        if (phases_run == 5 && r == records / 2) begin
          push_i <= 1'b0;
          wait (boxes_waiting == 0);
          @(negedge clk_i);
        end
        send_record(cc_eff, 5 + cc_eff, r == 0 && $urandom_range(0, 1));
      end
      if ($urandom_range(0, 2) == 0) send_record(cc_eff, $urandom_range(1, 4 + cc_eff), 1'b0);
      settle();
    end

    repeat (60) @(posedge clk_i);
    $display("Sent %0d logits over %0d random register phases plus directed extremes;",
             logits_sent, phases_run);
    $display("%0d boxes checked, %0d mismatches.", boxes_seen, mismatches);
    if (mismatches == 0 && boxes_waiting == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
